FILE: hw/rtl/fust_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fust_pkg
// Shared types and codes for the first-unique stream tracker.
// ----------------------------------------------------------------------------
package fust_pkg;

   // widest stream value the design supports, and width of the value ports
   localparam int MAX_VALUE_BITS = 16;
   localparam int PORT_VALUE_BITS = 8;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ADD_OK   = 2'd0,
      ST_ADD_DROP = 2'd1,
      ST_FOUND    = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   // occurrence count codes, saturating at two
   localparam logic [1:0] CNT_ONE = 2'd1;
   localparam logic [1:0] CNT_TWO = 2'd2;

   // command passed from the front end to the execution engine
   typedef struct packed {
      op_type                    op;
      logic [MAX_VALUE_BITS-1:0] value;
   } cmd_type;

endpackage

FILE: hw/rtl/fust_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fust_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fust_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fust_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fust_front
// Accepts commands, decodes and masks them, and buffers them in a
// two-entry queue ahead of the execution engine.
// ----------------------------------------------------------------------------
module fust_front #(
   parameter int VALUE_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_operation,
   input  logic [7:0]          req_value,
   input  logic                hold,
   output logic                busy,
   output logic                cmd_valid,
   output fust_pkg::cmd_type   cmd,
   input  logic                cmd_pop
);

   fust_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   fust_pkg::cmd_type push_cmd;
   logic [fust_pkg::MAX_VALUE_BITS-1:0] value_wide;

   assign busy = count_ff[1] | hold;
   assign push = start & ~busy;

   // drop value bits above VALUE_BITS
   always_comb begin
      value_wide = '0;
      value_wide[fust_pkg::PORT_VALUE_BITS-1:0] = req_value;
      push_cmd.op = fust_pkg::op_type'(req_operation);
      push_cmd.value = '0;
      push_cmd.value[VALUE_BITS-1:0] = value_wide[VALUE_BITS-1:0];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/fust_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fust_back
// Execution engine: clears the count table after reset, then runs adds
// (count read-modify-write plus order push) and queries (head pruning).
// ----------------------------------------------------------------------------
module fust_back #(
   parameter int VALUE_BITS  = 8,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  fust_pkg::cmd_type   cmd,
   output logic                cmd_pop,
   output logic                init_busy,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_unique_value
);

   localparam int NUM_VALUES = 1 << VALUE_BITS;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_ADD_RD = 6'b000100,
      S_Q_FIFO = 6'b001000,
      S_Q_CNT  = 6'b010000,
      S_UNUSED = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [VALUE_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [VALUE_BITS-1:0] cur_value_ff, cur_value_in;
   logic                  strobe_ff, strobe_in;
   logic [1:0]            status_ff, status_in;
   logic [7:0]            uvalue_ff, uvalue_in;

   logic                  cnt_wr_en, cnt_rd_en;
   logic [VALUE_BITS-1:0] cnt_wr_addr, cnt_rd_addr;
   logic [1:0]            cnt_wr_data, cnt_rd_data;
   logic                  fifo_wr_en, fifo_rd_en;
   logic [PTR_W-1:0]      fifo_rd_addr;
   logic [VALUE_BITS-1:0] fifo_rd_data;
   logic [VALUE_BITS-1:0] cmd_value;
   logic [fust_pkg::MAX_VALUE_BITS-1:0] head_wide;

   assign cmd_value = cmd.value[VALUE_BITS-1:0];

   always_comb begin
      head_wide = '0;
      head_wide[VALUE_BITS-1:0] = cur_value_ff;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      clr_addr_in  = clr_addr_ff;
      cur_value_in = cur_value_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      uvalue_in    = uvalue_ff;
      cmd_pop      = 1'b0;
      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = cur_value_ff;
      cnt_wr_data  = 2'd0;
      cnt_rd_en    = 1'b0;
      cnt_rd_addr  = cmd_value;
      fifo_wr_en   = 1'b0;
      fifo_rd_en   = 1'b0;
      fifo_rd_addr = head_ff;

      case (state_ff)
         S_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (&clr_addr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == fust_pkg::OP_ADD) begin
                  if (fill_ff == FILL_FULL) begin
                     strobe_in = 1'b1;
                     status_in = fust_pkg::ST_ADD_DROP;
                     uvalue_in = 8'd0;
                  end else begin
                     fifo_wr_en   = 1'b1;
                     tail_in      = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
                     fill_in      = fill_ff + 1'b1;
                     cnt_rd_en    = 1'b1;
                     cur_value_in = cmd_value;
                     state_in     = S_ADD_RD;
                  end
               end else if (fill_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = fust_pkg::ST_NONE;
                  uvalue_in = 8'd0;
               end else begin
                  fifo_rd_en = 1'b1;
                  state_in   = S_Q_FIFO;
               end
            end
         end
         S_ADD_RD: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_data = (cnt_rd_data == fust_pkg::CNT_TWO) ? fust_pkg::CNT_TWO
                                                             : cnt_rd_data + 1'b1;
            strobe_in   = 1'b1;
            status_in   = fust_pkg::ST_ADD_OK;
            uvalue_in   = 8'd0;
            state_in    = S_IDLE;
         end
         S_Q_FIFO: begin
            cur_value_in = fifo_rd_data;
            cnt_rd_en    = 1'b1;
            cnt_rd_addr  = fifo_rd_data;
            state_in     = S_Q_CNT;
         end
         S_Q_CNT: begin
            if (cnt_rd_data == fust_pkg::CNT_ONE) begin
               strobe_in = 1'b1;
               status_in = fust_pkg::ST_FOUND;
               uvalue_in = head_wide[7:0];
               state_in  = S_IDLE;
            end else begin
               // head is repeated: retire it for good
               head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
               if (fill_ff == FILL_W'(1)) begin
                  strobe_in = 1'b1;
                  status_in = fust_pkg::ST_NONE;
                  uvalue_in = 8'd0;
                  state_in  = S_IDLE;
               end else begin
                  fifo_rd_en   = 1'b1;
                  fifo_rd_addr = head_in;
                  state_in     = S_Q_FIFO;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         clr_addr_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fill_ff     <= fill_in;
         clr_addr_ff <= clr_addr_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_value_ff <= cur_value_in;
      status_ff    <= status_in;
      uvalue_ff    <= uvalue_in;
   end

   fust_ram #(
      .WIDTH (2),
      .DEPTH (NUM_VALUES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   fust_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (fifo_wr_en),
      .wr_addr (tail_ff),
      .wr_data (cmd_value),
      .rd_en   (fifo_rd_en),
      .rd_addr (fifo_rd_addr),
      .rd_data (fifo_rd_data)
   );

   assign init_busy        = (state_ff == S_CLEAR);
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_unique_value = uvalue_ff;

endmodule

FILE: hw/rtl/first_unique_stream_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_unique_stream_tracker_top
// Tracks the oldest stream value seen exactly once; adds push values,
// queries prune repeated head entries and report the head.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  request   req_operation, req_value                start & !busy
//  response  rsp_status, rsp_unique_value            rsp_strobe (one cycle)
//
//  Add: count read, then count write-back in the engine; a drop or an
//  empty query is answered from idle. Query: an order-RAM read, then a
//  count-RAM read, per head entry examined, in a shared read sequence.
//  After reset the count table is cleared, all 2**VALUE_BITS entries, busy high.
//  A two-entry command queue lets start be taken while the engine works;
//  busy rises when it is full. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
module first_unique_stream_tracker_top #(
   parameter int VALUE_BITS  = 8,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic [7:0] req_value,
   output logic       rsp_strobe,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_unique_value
);

   logic              cmd_valid;
   logic              cmd_pop;
   logic              init_busy;
   fust_pkg::cmd_type cmd;

   fust_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .req_value     (req_value),
      .hold          (init_busy),
      .busy          (busy),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   fust_back #(
      .VALUE_BITS  (VALUE_BITS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .init_busy        (init_busy),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_unique_value (rsp_unique_value)
   );

endmodule
